FILE: rtl/lcf_pkg.sv
// Shared types, constants and result builders for the LED color fade controller.
package lcf_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned LineLen = 6;
    localparam int unsigned PosW = 3;
    localparam int unsigned BitCntW = 3;

    localparam logic [ByteW-1:0] CHAR_CR = 8'h0D;
    localparam logic [ByteW-1:0] CHAR_LF = 8'h0A;
    localparam logic [ByteW-1:0] FADE_STEPS_RST = 8'd100;
    localparam logic [ByteW-1:0] FULL_ON = 8'hFF;

    // Configuration register indexes
    localparam logic REG_FADE_STEPS = 1'b0;
    localparam logic REG_SERIAL_EN = 1'b1;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_RX = 1'b1;
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_ECHO = 1'b1;

    typedef struct packed {
        logic             action;
        logic [ByteW-1:0] rx_byte;
        logic             switch_a_pressed;
        logic             switch_b_pressed;
        logic             switch_c_pressed;
    } t_in;

    typedef struct packed {
        logic             kind;
        logic [ByteW-1:0] echo_byte;
        logic [ByteW-1:0] red;
        logic [ByteW-1:0] green;
        logic [ByteW-1:0] blue;
        logic             fading;
        logic             last;
    } t_out;

    typedef struct packed {
        logic [ByteW-1:0] red;
        logic [ByteW-1:0] green;
        logic [ByteW-1:0] blue;
    } t_rgb;

    function automatic t_out make_frame(t_rgb c, logic fading);
        t_out o;
        o.kind      = KIND_FRAME;
        o.echo_byte = '0;
        o.red       = c.red;
        o.green     = c.green;
        o.blue      = c.blue;
        o.fading    = fading;
        o.last      = 1'b1;
        return o;
    endfunction

    function automatic t_out make_echo(logic [ByteW-1:0] b, logic last);
        t_out o;
        o.kind      = KIND_ECHO;
        o.echo_byte = b;
        o.red       = '0;
        o.green     = '0;
        o.blue      = '0;
        o.fading    = 1'b0;
        o.last      = last;
        return o;
    endfunction

endpackage

FILE: rtl/led_color_fade_controller.sv
// LED color fade controller: fades one RGB color toward switch or serial targets.
//
// Input channel (i_in_valid / o_in_ready, payload i_in): each request is either a tick
// carrying the three switch levels or a received serial byte. Output channel
// (o_out_valid / i_out_ready, payload o_out) returns a color frame per tick and one echo
// per serial byte, two (CR then LF) for a carriage return; last marks the final one.
// Serial bytes are dropped without a result while serial_enabled is 0.
// Configuration: i_cfg_we writes i_cfg_wdata into register i_cfg_idx (0 fade_steps,
// 1 serial_enabled) in the same cycle; write only while the block is idle.
// Sequence: a tick while a fade is in progress is accepted, then S_DIV runs the three
// bit-serial dividers side by side (one quotient bit each cycle), then S_FRAME loads the
// output register once it is free. A tick with no steps left, and any echoed serial
// byte, appear in the output register in the cycle after acceptance; the LF of a
// carriage return follows in the cycle after the CR is taken.
// One request is worked on at a time; the next is accepted once the block is idle and
// the output register is empty or being drained. A stalled receiver holds the result
// in the output register and blocks further requests.
// Reset: color black, goal white with 100 steps left, line store empty, serial off.
module led_color_fade_controller (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  lcf_pkg::t_in                  i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output lcf_pkg::t_out                 o_out,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [lcf_pkg::ByteW-1:0]     i_cfg_wdata
);
    import lcf_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_FRAME, S_LF} t_state;

    t_state              r_state;
    logic                r_out_valid;
    t_out                r_out;
    logic [ByteW-1:0]    r_fade_steps;
    logic                r_serial_en;
    t_rgb                r_now;
    t_rgb                r_goal;
    logic [ByteW-1:0]    r_remaining;
    logic [2:0]          r_held;
    logic [BitCntW-1:0]  r_bit_cnt;
    logic                r_fading;

    logic                w_in_acc;
    logic                w_out_free;
    logic                w_tick;
    logic                w_rx;
    logic                w_cr;
    logic [2:0]          w_levels;
    logic [2:0]          w_rise;
    t_rgb                n_goal;
    logic [ByteW-1:0]    n_remaining;
    t_rgb                w_next;
    t_rgb                w_line_goal;
    logic                w_start;
    logic                w_step;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_out_free;
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_tick     = w_in_acc && (i_in.action == ACT_TICK);
    assign w_rx       = w_in_acc && (i_in.action == ACT_RX) && r_serial_en;
    assign w_cr       = w_rx && (i_in.rx_byte == CHAR_CR);

    assign w_levels = {i_in.switch_c_pressed, i_in.switch_b_pressed, i_in.switch_a_pressed};
    assign w_rise   = w_levels & ~r_held;

    // Later switch in A, B, C order wins
    always_comb begin
        n_goal      = r_goal;
        n_remaining = r_remaining;
        if (w_rise[0]) begin
            n_goal = '{red: '0, green: FULL_ON, blue: FULL_ON};
        end
        if (w_rise[1]) begin
            n_goal = '{red: FULL_ON, green: FULL_ON, blue: FULL_ON};
        end
        if (w_rise[2]) begin
            n_goal = '{red: '0, green: '0, blue: '0};
        end
        if (|w_rise) begin
            n_remaining = r_fade_steps;
        end
    end

    assign w_start = w_tick && (n_remaining != '0);
    assign w_step  = (r_state == S_DIV);

    lcf_channel u_red (
        .i_clk   (i_clk),
        .i_start (w_start),
        .i_step  (w_step),
        .i_cur   (r_now.red),
        .i_goal  (n_goal.red),
        .i_steps (n_remaining),
        .o_next  (w_next.red)
    );

    lcf_channel u_green (
        .i_clk   (i_clk),
        .i_start (w_start),
        .i_step  (w_step),
        .i_cur   (r_now.green),
        .i_goal  (n_goal.green),
        .i_steps (n_remaining),
        .o_next  (w_next.green)
    );

    lcf_channel u_blue (
        .i_clk   (i_clk),
        .i_start (w_start),
        .i_step  (w_step),
        .i_cur   (r_now.blue),
        .i_goal  (n_goal.blue),
        .i_steps (n_remaining),
        .o_next  (w_next.blue)
    );

    lcf_line u_line (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_rx && !w_cr),
        .i_clr   (w_cr),
        .i_char  (i_in.rx_byte),
        .o_goal  (w_line_goal)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_fade_steps <= FADE_STEPS_RST;
            r_serial_en  <= 1'b0;
            r_now        <= '0;
            r_goal       <= '{red: FULL_ON, green: FULL_ON, blue: FULL_ON};
            r_remaining  <= FADE_STEPS_RST;
            r_held       <= '0;
            r_bit_cnt    <= '0;
            r_fading     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_FADE_STEPS: r_fade_steps <= i_cfg_wdata;
                    REG_SERIAL_EN:  r_serial_en  <= i_cfg_wdata[0];
                    default:        r_serial_en  <= r_serial_en;
                endcase
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_tick) begin
                        r_held      <= w_levels;
                        r_goal      <= n_goal;
                        r_remaining <= n_remaining;
                        if (n_remaining != '0) begin
                            r_fading  <= 1'b1;
                            r_bit_cnt <= '0;
                            r_state   <= S_DIV;
                        end else begin
                            r_out       <= make_frame(r_now, 1'b0);
                            r_out_valid <= 1'b1;
                        end
                    end else if (w_rx) begin
                        r_out       <= make_echo(i_in.rx_byte, !w_cr);
                        r_out_valid <= 1'b1;
                        if (w_cr) begin
                            r_goal      <= w_line_goal;
                            r_remaining <= r_fade_steps;
                            r_state     <= S_LF;
                        end
                    end
                end
                S_DIV: begin
                    r_bit_cnt <= r_bit_cnt + 1'b1;
                    if (r_bit_cnt == '1) begin
                        r_state <= S_FRAME;
                    end
                end
                S_FRAME: begin
                    if (w_out_free) begin
                        r_now       <= w_next;
                        r_remaining <= r_remaining - 1'b1;
                        r_out       <= make_frame(w_next, r_fading);
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_LF: begin
                    if (w_out_free) begin
                        r_out       <= make_echo(CHAR_LF, 1'b1);
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Never divide by a zero step count
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_remaining != '0))
        else $error("divide running with no steps left");

    // A carriage return always schedules the line feed
    a_cr_then_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cr |=> (r_state == S_LF) && o_out_valid && !o_out.last)
        else $error("carriage return did not queue line feed");

    // Color frames are always the final result of their tick
    a_frame_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.kind == KIND_FRAME) |-> o_out.last)
        else $error("color frame without last");

endmodule

FILE: rtl/lcf_channel.sv
// One color channel: bit-serial restoring divide of the distance, then step toward the goal.
module lcf_channel (
    input  logic                     i_clk,
    input  logic                     i_start,
    input  logic                     i_step,
    input  logic [lcf_pkg::ByteW-1:0] i_cur,
    input  logic [lcf_pkg::ByteW-1:0] i_goal,
    input  logic [lcf_pkg::ByteW-1:0] i_steps,
    output logic [lcf_pkg::ByteW-1:0] o_next
);
    import lcf_pkg::*;

    logic             r_down;
    logic [ByteW-1:0] r_cur;
    logic [ByteW-1:0] r_div;
    logic [ByteW-1:0] r_quo;
    logic [ByteW-1:0] r_rem;
    logic [ByteW:0]   w_trial;
    logic [ByteW:0]   w_diff;
    logic             w_ge;

    assign w_trial = {r_rem, r_quo[ByteW-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    // Dividend shifts out the top while quotient bits shift in below
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_down <= i_cur > i_goal;
            r_quo  <= (i_cur > i_goal) ? i_cur - i_goal : i_goal - i_cur;
            r_rem  <= '0;
            r_div  <= i_steps;
            r_cur  <= i_cur;
        end else if (i_step) begin
            r_rem <= w_ge ? w_diff[ByteW-1:0] : w_trial[ByteW-1:0];
            r_quo <= {r_quo[ByteW-2:0], w_ge};
        end
    end

    assign o_next = r_down ? r_cur - r_quo : r_cur + r_quo;

endmodule

FILE: rtl/lcf_line.sv
// Serial line store: keeps the hex nibbles of the first six characters of a line.
module lcf_line (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_wr,
    input  logic                      i_clr,
    input  logic [lcf_pkg::ByteW-1:0] i_char,
    output lcf_pkg::t_rgb             o_goal
);
    import lcf_pkg::*;

    logic [3:0]      r_nib [LineLen];
    logic [PosW-1:0] r_pos;

    function automatic logic [3:0] nibble_of(logic [ByteW-1:0] c);
        logic [ByteW-1:0] lc;
        lc = c | 8'h20;
        if (c >= "0" && c <= "9") return c[3:0];
        if (lc >= "a" && lc <= "f") return 4'(lc - "a" + 8'd10);
        return 4'd0;
    endfunction

    // Store decoded nibbles; non-hex and unreceived characters read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_pos <= '0;
            for (int k = 0; k < LineLen; k++) begin
                r_nib[k] <= '0;
            end
        end else if (i_wr && r_pos < PosW'(LineLen)) begin
            r_nib[r_pos] <= nibble_of(i_char);
            r_pos        <= r_pos + 1'b1;
        end
    end

    assign o_goal.red   = {r_nib[0], r_nib[1]};
    assign o_goal.green = {r_nib[2], r_nib[3]};
    assign o_goal.blue  = {r_nib[4], r_nib[5]};

endmodule
